### hdl/pdu_pkg.sv
// Types, constants and byte-level UTF-8 decode functions for the percent decoder.
`timescale 1ns / 1ps
`default_nettype none

package pdu_pkg;

  localparam logic [15:0] UNIT_PERCENT = 16'h0025;
  localparam logic [15:0] UNIT_PLUS    = 16'h002B;
  localparam logic [15:0] UNIT_MAX_RAW = 16'h007F;
  localparam logic [7:0]  BYTE_PERCENT = 8'h25;
  localparam logic [7:0]  BYTE_SPACE   = 8'h20;
  localparam int unsigned MAX_RESULTS  = 4;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  localparam logic [2:0] RULE_ANY = 3'd0;
  localparam logic [2:0] RULE_E0  = 3'd1;
  localparam logic [2:0] RULE_ED  = 3'd2;
  localparam logic [2:0] RULE_F0  = 3'd3;
  localparam logic [2:0] RULE_F4  = 3'd4;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_RAW  = 2'd1;
  localparam logic [1:0] ERR_UTF8 = 2'd2;

  typedef struct packed {
    logic [1:0] phase;
    logic [6:0] held;
  } esc_state_t;

  typedef struct packed {
    logic [1:0]  cont;
    logic [20:0] acc;
    logic [2:0]  rule;
    logic [1:0]  err;
  } dec_state_t;

  typedef struct packed {
    dec_state_t  st;
    logic [1:0]  n;
    logic [15:0] u0;
    logic [15:0] u1;
  } feed_ret_t;

  typedef struct packed {
    logic [15:0] unit;
    logic        present;
    logic        eos;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [2:0]                count;
  } bundle_t;

  function automatic logic is_hex(logic [15:0] u);
    return (u >= 16'h0030 && u <= 16'h0039) || (u >= 16'h0041 && u <= 16'h0046) ||
           (u >= 16'h0061 && u <= 16'h0066);
  endfunction

  function automatic logic [3:0] nibble(logic [6:0] c);
    logic [6:0] v;
    if (c <= 7'h39) begin
      v = c - 7'h30;
    end else if (c <= 7'h46) begin
      v = c - 7'h37;
    end else begin
      v = c - 7'h57;
    end
    return v[3:0];
  endfunction

  function automatic feed_ret_t emit_cp(feed_ret_t r_in, logic [20:0] cp);
    feed_ret_t  r;
    logic [20:0] v;
    r = r_in;
    v = cp - 21'h010000;
    if (cp >= 21'h010000) begin
      r.n  = 2'd2;
      r.u0 = {6'b110110, v[19:10]};
      r.u1 = {6'b110111, v[9:0]};
    end else begin
      r.n  = 2'd1;
      r.u0 = cp[15:0];
    end
    return r;
  endfunction

  function automatic feed_ret_t feed_byte(dec_state_t s, logic [7:0] b);
    feed_ret_t   r;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [20:0] acc;
    r    = '0;
    r.st = s;
    lo   = 8'h80;
    hi   = 8'hBF;
    acc  = {s.acc[14:0], b[5:0]};
    if (s.err == ERR_NONE) begin
      if (s.cont == 2'd0) begin
        if (b < 8'h80) begin
          r = emit_cp(r, {13'd0, b});
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
          r.st.acc  = {16'd0, b[4:0]};
          r.st.cont = 2'd1;
          r.st.rule = RULE_ANY;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          r.st.acc  = {17'd0, b[3:0]};
          r.st.cont = 2'd2;
          r.st.rule = (b == 8'hE0) ? RULE_E0 : (b == 8'hED) ? RULE_ED : RULE_ANY;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          r.st.acc  = {18'd0, b[2:0]};
          r.st.cont = 2'd3;
          r.st.rule = (b == 8'hF0) ? RULE_F0 : (b == 8'hF4) ? RULE_F4 : RULE_ANY;
        end else begin
          r.st.err = ERR_UTF8;
        end
      end else begin
        case (s.rule)
          RULE_E0: lo = 8'hA0;
          RULE_ED: hi = 8'h9F;
          RULE_F0: lo = 8'h90;
          RULE_F4: hi = 8'h8F;
          default: ;
        endcase
        if (b < lo || b > hi) begin
          r.st.err  = ERR_UTF8;
          r.st.cont = 2'd0;
        end else begin
          r.st.acc  = acc;
          r.st.rule = RULE_ANY;
          r.st.cont = s.cont - 2'd1;
          if (s.cont == 2'd1) begin
            r = emit_cp(r, acc);
          end
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/percent_decode_utf8_to_utf16.sv
// Top level of the percent decoder with UTF-8 to UTF-16 conversion and result drain.
//
// Takes one UTF-16 code unit per cycle while item_stall is low. Each accepted unit is
// decoded in a single registered pass into a bundle of zero to four results, which are
// then delivered one per cycle while result_stall is low. The next item is taken in
// the cycle that the last result of the bundle leaves, or as soon as it is offered when
// no results are left. The final unit of a string adds an
// end-of-string result carrying the status (0 ok, 1 raw unit above 0x7F, 2 invalid
// UTF-8); on nonzero status the whole string is to be discarded.
`timescale 1ns / 1ps
`default_nettype none

module percent_decode_utf8_to_utf16 (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [15:0] code_unit,
  input  logic        is_final,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [15:0] out_unit,
  output logic        unit_present,
  output logic        end_of_string,
  output logic [1:0]  status
);
  import pdu_pkg::*;

  esc_state_t esc;
  esc_state_t esc_next;
  dec_state_t dec;
  dec_state_t dec_next;
  bundle_t    bundle_next;
  result_t [MAX_RESULTS-1:0] slots;
  logic [2:0] left;
  logic [1:0] idx;
  logic       accept;
  logic       pop;
  result_t    cur;

  pdu_step u_step (
    .code_unit (code_unit),
    .is_final  (is_final),
    .esc       (esc),
    .dec       (dec),
    .esc_next  (esc_next),
    .dec_next  (dec_next),
    .bundle    (bundle_next)
  );

  assign result_valid = (left != 3'd0);
  assign pop          = result_valid && !result_stall;
  assign item_stall   = !((left == 3'd0) || (left == 3'd1 && !result_stall));
  assign accept       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      esc  <= '0;
      dec  <= '0;
      left <= 3'd0;
      idx  <= 2'd0;
    end else if (accept) begin
      esc  <= esc_next;
      dec  <= dec_next;
      left <= bundle_next.count;
      idx  <= 2'd0;
    end else if (pop) begin
      left <= left - 3'd1;
      idx  <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slots <= bundle_next.res;
    end
  end

  assign cur           = slots[idx];
  assign out_unit      = cur.unit;
  assign unit_present  = cur.present;
  assign end_of_string = cur.eos;
  assign status        = cur.status;

endmodule

`default_nettype wire

### hdl/pdu_step.sv
// Per-unit escape handling and UTF-8 to UTF-16 decode producing one result bundle.
`timescale 1ns / 1ps
`default_nettype none

module pdu_step (
  input  logic [15:0]         code_unit,
  input  logic                is_final,
  input  pdu_pkg::esc_state_t esc,
  input  pdu_pkg::dec_state_t dec,
  output pdu_pkg::esc_state_t esc_next,
  output pdu_pkg::dec_state_t dec_next,
  output pdu_pkg::bundle_t    bundle
);
  import pdu_pkg::*;

  logic [3:0][7:0] byte_q;
  logic [2:0]      nb;
  logic            raw_err;
  logic            hex;
  logic            in_escape;
  esc_state_t      esc_w;
  dec_state_t      d;
  feed_ret_t       fr;
  bundle_t         bun;

  assign hex       = is_hex(code_unit);
  assign in_escape = (esc.phase == PH_PCT) || (esc.phase == PH_DIGIT);

  always_comb begin
    byte_q  = '0;
    nb      = 3'd0;
    raw_err = 1'b0;
    esc_w.phase = PH_IDLE;
    esc_w.held  = esc.held;
    if (esc.phase == PH_PCT && hex) begin
      esc_w.held  = code_unit[6:0];
      esc_w.phase = PH_DIGIT;
    end else if (esc.phase == PH_DIGIT && hex) begin
      byte_q[nb[1:0]] = {nibble(esc.held), nibble(code_unit[6:0])};
      nb = nb + 3'd1;
    end else begin
      if (in_escape) begin
        byte_q[nb[1:0]] = BYTE_PERCENT;
        nb = nb + 3'd1;
      end
      if (esc.phase == PH_DIGIT) begin
        byte_q[nb[1:0]] = {1'b0, esc.held};
        nb = nb + 3'd1;
      end
      if (code_unit == UNIT_PERCENT) begin
        esc_w.phase = PH_PCT;
      end else if (code_unit == UNIT_PLUS) begin
        byte_q[nb[1:0]] = BYTE_SPACE;
        nb = nb + 3'd1;
      end else if (code_unit <= UNIT_MAX_RAW) begin
        byte_q[nb[1:0]] = code_unit[7:0];
        nb = nb + 3'd1;
      end else begin
        raw_err = 1'b1;
      end
    end
    if (is_final) begin
      if (esc_w.phase == PH_PCT || esc_w.phase == PH_DIGIT) begin
        byte_q[nb[1:0]] = BYTE_PERCENT;
        nb = nb + 3'd1;
      end
      if (esc_w.phase == PH_DIGIT) begin
        byte_q[nb[1:0]] = {1'b0, esc_w.held};
        nb = nb + 3'd1;
      end
    end
  end

  always_comb begin
    d   = dec;
    fr  = '0;
    bun = '0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < nb) begin
        fr = feed_byte(d, byte_q[i]);
        d  = fr.st;
        for (int j = 0; j < 2; j++) begin
          if (2'(j) < fr.n && bun.count < 3'(MAX_RESULTS)) begin
            bun.res[bun.count[1:0]].unit    = (j == 0) ? fr.u0 : fr.u1;
            bun.res[bun.count[1:0]].present = 1'b1;
            bun.count = bun.count + 3'd1;
          end
        end
      end
    end
    if (raw_err) begin
      d.err = ERR_RAW;
    end
    esc_next = esc_w;
    dec_next = d;
    if (is_final) begin
      if (d.cont != 2'd0 && d.err == ERR_NONE) begin
        d.err = ERR_UTF8;
      end
      if (bun.count < 3'(MAX_RESULTS)) begin
        bun.res[bun.count[1:0]].eos    = 1'b1;
        bun.res[bun.count[1:0]].status = d.err;
        bun.count = bun.count + 3'd1;
      end
      esc_next = '0;
      dec_next = '0;
    end
    bundle = bun;
  end

endmodule

`default_nettype wire
